// ===== rtl/calibrated_sensor_scaler_averager_assert.svh =====
// Assertion macros shared by the scaler controller and datapath.
// Needs nothing else; include inside a module after its signals are declared.
`ifndef CALIBRATED_SENSOR_SCALER_AVERAGER_ASSERT_SVH
`define CALIBRATED_SENSOR_SCALER_AVERAGER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CSS_ASSERT_IMPL(name, clk_i, rst_i, ante, cons, msg) \
    name: assert property (@(posedge clk_i) disable iff (!rst_i) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CSS_ASSERT_NEXT(name, clk_i, rst_i, ante, cons, msg) \
    name: assert property (@(posedge clk_i) disable iff (!rst_i) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/css_pkg.sv =====
// Shared types and constants of the calibrated sensor scaler and averager.
// Used by every module of the block but css_ram; depends on nothing.
`default_nettype none

package css_pkg;

    typedef enum logic [1:0] {
        FUNC_PROCESS   = 2'd0,
        FUNC_CALIBRATE = 2'd1,
        FUNC_RESET_CAL = 2'd2,
        FUNC_CLEAR     = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        SEL_BYTE = 2'd0,
        SEL_WIDE = 2'd1,
        SEL_AVG  = 2'd2
    } div_sel_t;

    localparam logic signed [15:0] CAL_MIN_RESET = 16'sd32000;
    localparam logic signed [15:0] CAL_MAX_RESET = -16'sd32000;

    localparam logic [9:0] TOP_BYTE = 10'd255;
    localparam logic [9:0] TOP_WIDE = 10'd1023;

    localparam int DIV_W  = 26;
    localparam int DVS_W  = 16;
    localparam int Q_W    = 16;
    localparam int STEP_W = 5;

    localparam logic [STEP_W-1:0] STEPS_BYTE = 5'd8;
    localparam logic [STEP_W-1:0] STEPS_WIDE = 5'd10;
    localparam logic [STEP_W-1:0] STEPS_AVG  = 5'd16;

    typedef struct packed {
        logic     load_in;
        logic     apply_op;
        logic     div_start;
        div_sel_t div_sel;
        logic     div_store;
        logic     push;
        logic     avg_clear;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        func_t func;
        logic  map_ok;
        logic  count_nz;
        logic  div_done;
        logic  out_free;
    } ctrl_status_t;

endpackage

`default_nettype wire

// ===== rtl/css_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; holds the averaging window of the datapath.
`default_nettype none

module css_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/css_div.sv =====
// Serial restoring divider, one quotient bit per cycle, with an early overflow check.
// Depends on css_pkg for widths.
`default_nettype none

module css_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [css_pkg::DIV_W-1:0]     dividend,
    input  wire logic [css_pkg::DVS_W-1:0]     divisor,
    input  wire logic [css_pkg::STEP_W-1:0]    steps,
    output logic                               done,
    output logic      [css_pkg::Q_W-1:0]       quotient,
    output logic                               overflow
);

    import css_pkg::*;

    logic              busy_reg, busy_next;
    logic              first_reg, first_next;
    logic              done_reg, done_next;
    logic              ovf_reg, ovf_next;
    logic [STEP_W-1:0] steps_reg, steps_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  low_reg, low_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [Q_W-1:0]    q_reg, q_next;

    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    trial_sub;
    logic              trial_ge;
    logic [STEP_W-1:0] shl;

    assign trial     = {rem_reg[DVS_W-1:0], low_reg[DIV_W-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign trial_ge  = (trial >= {1'b0, dvs_reg});
    assign shl       = STEP_W'(DIV_W) - steps;

    always_comb
    begin
        busy_next  = busy_reg;
        first_next = first_reg;
        done_next  = 1'b0;
        ovf_next   = ovf_reg;
        steps_next = steps_reg;
        rem_next   = rem_reg;
        low_next   = low_reg;
        dvs_next   = dvs_reg;
        q_next     = q_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            first_next = 1'b1;
            ovf_next   = 1'b0;
            steps_next = steps;
            rem_next   = dividend >> steps;
            low_next   = dividend << shl;
            dvs_next   = divisor;
            q_next     = '0;
        end
        else if (busy_reg)
        begin
            if (first_reg)
            begin
                first_next = 1'b0;
                if (rem_reg >= DIV_W'(dvs_reg))
                begin
                    ovf_next  = 1'b1;
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
            else
            begin
                rem_next   = trial_ge ? DIV_W'(trial_sub) : DIV_W'(trial);
                low_next   = {low_reg[DIV_W-2:0], 1'b0};
                q_next     = {q_reg[Q_W-2:0], trial_ge};
                steps_next = steps_reg - STEP_W'(1);
                if (steps_reg == STEP_W'(1))
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            first_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            first_reg <= first_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ovf_reg   <= ovf_next;
        steps_reg <= steps_next;
        rem_reg   <= rem_next;
        low_reg   <= low_next;
        dvs_reg   <= dvs_next;
        q_reg     <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;
    assign overflow = ovf_reg;

endmodule

`default_nettype wire

// ===== rtl/css_datapath.sv =====
// Datapath: calibration range, scaling operands, window ring with running sum, output word.
// Depends on css_pkg, css_div, css_ram and the assertion macro header.
`default_nettype none

`include "calibrated_sensor_scaler_averager_assert.svh"

module css_datapath #(
    parameter int WINDOW = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [1:0]                 func,
    input  wire logic signed [15:0]         sample,
    input  wire css_pkg::ctrl_cmd_t         cmd,
    output css_pkg::ctrl_status_t           status,
    input  wire logic                       out_stall,
    output logic                            out_valid,
    output logic [7:0]                      scaled_byte,
    output logic [9:0]                      scaled_wide,
    output logic [15:0]                     average_q8,
    output logic                            average_valid,
    output logic [4:0]                      fill_count,
    output logic signed [15:0]              cal_low,
    output logic signed [15:0]              cal_high
);

    import css_pkg::*;

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = 8 + CNT_W;

    func_t              func_reg, func_next;
    logic signed [15:0] sample_reg, sample_next;
    logic signed [15:0] cal_min_reg, cal_min_next;
    logic signed [15:0] cal_max_reg, cal_max_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [7:0]         sb_reg, sb_next;
    logic [9:0]         sw_reg, sw_next;
    logic [15:0]        avg_reg, avg_next;
    div_sel_t           sel_reg, sel_next;

    logic               out_valid_reg, out_valid_next;
    logic [7:0]         ob_reg, ob_next;
    logic [9:0]         ow_reg, ow_next;
    logic [15:0]        oa_reg, oa_next;
    logic               oav_reg, oav_next;
    logic [4:0]         of_reg, of_next;
    logic signed [15:0] ol_reg, ol_next;
    logic signed [15:0] oh_reg, oh_next;

    logic signed [16:0] diff;
    logic signed [16:0] span;
    logic               map_ok;
    logic [9:0]         top_sel;
    logic [DIV_W-1:0]   map_prod;
    logic [DIV_W-1:0]   div_dividend;
    logic [DVS_W-1:0]   div_divisor;
    logic [STEP_W-1:0]  div_steps;
    logic               div_done;
    logic [Q_W-1:0]     div_q;
    logic               div_ovf;
    logic [7:0]         old_val;
    logic               full;
    logic               out_free;

    assign diff     = {sample_reg[15], sample_reg} - {cal_min_reg[15], cal_min_reg};
    assign span     = {cal_max_reg[15], cal_max_reg} - {cal_min_reg[15], cal_min_reg};
    assign map_ok   = !span[16] && (span != 17'sd0);
    assign top_sel  = (cmd.div_sel == SEL_WIDE) ? TOP_WIDE : TOP_BYTE;
    assign map_prod = diff[16] ? '0
                    : (DIV_W'(diff[15:0]) * DIV_W'(top_sel));
    assign full     = (count_reg == CNT_W'(WINDOW));
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (cmd.div_sel == SEL_AVG)
        begin
            div_dividend = DIV_W'({sum_reg, 8'd0});
            div_divisor  = DVS_W'(count_reg);
            div_steps    = STEPS_AVG;
        end
        else
        begin
            div_dividend = map_prod;
            div_divisor  = span[15:0];
            div_steps    = (cmd.div_sel == SEL_WIDE) ? STEPS_WIDE : STEPS_BYTE;
        end
    end

    css_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .done     (div_done),
        .quotient (div_q),
        .overflow (div_ovf)
    );

    css_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.push),
        .wr_addr (idx_reg),
        .wr_data (sb_reg),
        .rd_addr (idx_reg),
        .rd_data (old_val)
    );

    always_comb
    begin
        func_next    = func_reg;
        sample_next  = sample_reg;
        cal_min_next = cal_min_reg;
        cal_max_next = cal_max_reg;
        sum_next     = sum_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        sb_next      = sb_reg;
        sw_next      = sw_reg;
        avg_next     = avg_reg;
        sel_next     = sel_reg;

        if (cmd.load_in)
        begin
            func_next   = func_t'(func);
            sample_next = sample;
        end

        if (cmd.apply_op)
        begin
            sb_next = '0;
            sw_next = '0;
            unique case (func_reg)
                FUNC_PROCESS:
                begin
                end
                FUNC_CALIBRATE:
                begin
                    if (sample_reg > cal_max_reg)
                    begin
                        cal_max_next = sample_reg;
                    end
                    if (sample_reg < cal_min_reg)
                    begin
                        cal_min_next = sample_reg;
                    end
                end
                FUNC_RESET_CAL:
                begin
                    cal_min_next = CAL_MIN_RESET;
                    cal_max_next = CAL_MAX_RESET;
                end
                FUNC_CLEAR:
                begin
                    sum_next   = '0;
                    idx_next   = '0;
                    count_next = '0;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.div_start)
        begin
            sel_next = cmd.div_sel;
        end

        if (cmd.div_store)
        begin
            unique case (sel_reg)
                SEL_BYTE: sb_next  = div_ovf ? 8'(TOP_BYTE) : div_q[7:0];
                SEL_WIDE: sw_next  = div_ovf ? TOP_WIDE : div_q[9:0];
                SEL_AVG:  avg_next = div_q;
                default:  avg_next = avg_reg;
            endcase
        end

        if (cmd.push)
        begin
            sum_next = sum_reg - (full ? SUM_W'(old_val) : SUM_W'(0)) + SUM_W'(sb_reg);
            idx_next = (idx_reg == IDX_W'(WINDOW - 1)) ? '0 : idx_reg + IDX_W'(1);
            if (!full)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end

        if (cmd.avg_clear)
        begin
            avg_next = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        ob_next = ob_reg;
        ow_next = ow_reg;
        oa_next = oa_reg;
        oav_next = oav_reg;
        of_next = of_reg;
        ol_next = ol_reg;
        oh_next = oh_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            ob_next  = sb_reg;
            ow_next  = sw_reg;
            oa_next  = avg_reg;
            oav_next = (count_reg != '0);
            of_next  = 5'(count_reg);
            ol_next  = cal_min_reg;
            oh_next  = cal_max_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_min_reg   <= CAL_MIN_RESET;
            cal_max_reg   <= CAL_MAX_RESET;
            sum_reg       <= '0;
            idx_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cal_min_reg   <= cal_min_next;
            cal_max_reg   <= cal_max_next;
            sum_reg       <= sum_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        sample_reg <= sample_next;
        sb_reg     <= sb_next;
        sw_reg     <= sw_next;
        avg_reg    <= avg_next;
        sel_reg    <= sel_next;
        ob_reg     <= ob_next;
        ow_reg     <= ow_next;
        oa_reg     <= oa_next;
        oav_reg    <= oav_next;
        of_reg     <= of_next;
        ol_reg     <= ol_next;
        oh_reg     <= oh_next;
    end

    assign status.func     = func_reg;
    assign status.map_ok   = map_ok;
    assign status.count_nz = (count_reg != '0);
    assign status.div_done = div_done;
    assign status.out_free = out_free;

    assign out_valid     = out_valid_reg;
    assign scaled_byte   = ob_reg;
    assign scaled_wide   = ow_reg;
    assign average_q8    = oa_reg;
    assign average_valid = oav_reg;
    assign fill_count    = of_reg;
    assign cal_low       = ol_reg;
    assign cal_high      = oh_reg;

    `CSS_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(WINDOW),
        "window fill count above window size")
    `CSS_ASSERT_IMPL(a_idx_tracks_count, clk, rst_n, !full, CNT_W'(idx_reg) == count_reg,
        "write index out of step with fill count before the window fills")
    `CSS_ASSERT_IMPL(a_sum_bound, clk, rst_n, 1'b1,
        sum_reg <= SUM_W'(count_reg) * SUM_W'(8'd255),
        "running sum exceeds what the stored entries allow")

endmodule

`default_nettype wire

// ===== rtl/css_ctrl.sv =====
// Controller state machine: sequences decode, up to three divisions, ring update and output.
// Depends on css_pkg and the assertion macro header.
`default_nettype none

`include "calibrated_sensor_scaler_averager_assert.svh"

module css_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire css_pkg::ctrl_status_t  status,
    output css_pkg::ctrl_cmd_t          cmd
);

    import css_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_DECODE    = 8'b0000_0010,
        S_BYTE_RUN  = 8'b0000_0100,
        S_WIDE_RUN  = 8'b0000_1000,
        S_PUSH      = 8'b0001_0000,
        S_AVG_START = 8'b0010_0000,
        S_AVG_RUN   = 8'b0100_0000,
        S_FINISH    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = SEL_BYTE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.apply_op = 1'b1;
                if (status.func == FUNC_PROCESS && status.map_ok)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = SEL_BYTE;
                    state_next    = S_BYTE_RUN;
                end
                else if (status.func == FUNC_PROCESS)
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    state_next = S_AVG_START;
                end
            end
            S_BYTE_RUN:
            begin
                if (status.div_done)
                begin
                    cmd.div_store = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = SEL_WIDE;
                    state_next    = S_WIDE_RUN;
                end
            end
            S_WIDE_RUN:
            begin
                if (status.div_done)
                begin
                    cmd.div_store = 1'b1;
                    state_next    = S_PUSH;
                end
            end
            S_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = S_AVG_START;
            end
            S_AVG_START:
            begin
                cmd.avg_clear = 1'b1;
                if (status.count_nz)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = SEL_AVG;
                    state_next    = S_AVG_RUN;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_AVG_RUN:
            begin
                if (status.div_done)
                begin
                    cmd.div_store = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    `CSS_ASSERT_NEXT(a_accept_decode, clk, rst_n, in_valid && !in_stall,
        state_reg == S_DECODE, "accepted word not decoded next cycle")
    `CSS_ASSERT_IMPL(a_done_in_run, clk, rst_n, status.div_done,
        state_reg == S_BYTE_RUN || state_reg == S_WIDE_RUN || state_reg == S_AVG_RUN,
        "divider finished outside a division state")
    `CSS_ASSERT_NEXT(a_div_not_instant, clk, rst_n, cmd.div_start, !status.div_done,
        "divider reported done one cycle after start")

endmodule

`default_nettype wire

// ===== rtl/calibrated_sensor_scaler_averager.sv =====
// One word is in flight at a time; the next is accepted in the same cycle that out_valid
// rises. A held output word (out_valid with out_stall) delays the next output word.
// Time is set by one shared serial divider: a range check, then one quotient bit
// per cycle (8, 10, 16 bits). Reset: range 32000/-32000, empty window, fill count masks RAM.
// Depends on css_pkg, css_ctrl, css_datapath.
`default_nettype none

module calibrated_sensor_scaler_averager #(
    parameter int WINDOW = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         func,
    input  wire logic signed [15:0] sample,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [7:0]              scaled_byte,
    output logic [9:0]              scaled_wide,
    output logic [15:0]             average_q8,
    output logic                    average_valid,
    output logic [4:0]              fill_count,
    output logic signed [15:0]      cal_low,
    output logic signed [15:0]      cal_high
);

    import css_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    css_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    css_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .func          (func),
        .sample        (sample),
        .cmd           (cmd),
        .status        (status),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .scaled_byte   (scaled_byte),
        .scaled_wide   (scaled_wide),
        .average_q8    (average_q8),
        .average_valid (average_valid),
        .fill_count    (fill_count),
        .cal_low       (cal_low),
        .cal_high      (cal_high)
    );

endmodule

`default_nettype wire
